// ===== hdl/adsr_pkg.sv =====
// Package for the ADSR envelope generator: stage, sequencer and level-mode types,
// register indexes, field widths and reset values.
// No dependencies.
`default_nettype none

package adsr_pkg;

   localparam int LEN_BITS_DEFAULT = 19;
   localparam int LEVEL_W          = 16;
   localparam int VEL_W            = 7;
   localparam int STAGE_W          = 3;
   localparam int CSR_INDEX_W      = 2;
   localparam int QUOT_W           = 16;
   localparam int DIV_CNT_W        = 4;

   localparam logic [LEVEL_W-1:0] ONE_Q15       = 16'h8000;
   localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = 16'd16384;
   localparam int                 ATTACK_RESET  = 480;
   localparam int                 DECAY_RESET   = 4800;
   localparam int                 RELEASE_RESET = 4800;

   typedef enum logic [STAGE_W-1:0] {
      STAGE_ATTACK  = 3'd0,
      STAGE_DECAY   = 3'd1,
      STAGE_SUSTAIN = 3'd2,
      STAGE_RELEASE = 3'd3,
      STAGE_SILENT  = 3'd4
   } stage_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK_LENGTH  = 2'd0,
      CSR_DECAY_LENGTH   = 2'd1,
      CSR_SUSTAIN_LEVEL  = 2'd2,
      CSR_RELEASE_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_MUL  = 2'd1,
      SEQ_DIV  = 2'd2,
      SEQ_FIN  = 2'd3
   } seq_state_type;

   // how the output level is formed from the quotient
   typedef enum logic [2:0] {
      MODE_ATTACK  = 3'd0,
      MODE_DECAY   = 3'd1,
      MODE_RELEASE = 3'd2,
      MODE_SUSTAIN = 3'd3,
      MODE_ZERO    = 3'd4
   } mode_type;

endpackage

`default_nettype wire

// ===== hdl/adsr_envelope_generator_unit.sv =====
// Linear ADSR envelope generator, top level: stage tracking, multiply and
// restoring divider sequencer, output register. Depends on adsr_pkg.
//
// One request word per audio sample carries the note velocity; one response word
// returns the envelope level (Q1.15) and the stage reached. Ramp stages (attack,
// decay, release) pass through the accept state, a multiply state, the shared
// compare/subtract divider (one quotient bit per cycle) and a final state that
// loads the output register. Sustain, silent and note-on restart words skip the
// multiply and divider and go straight to that final state. The output register
// lets the next word be accepted while a response still waits; a word finishing
// before the previous response is taken holds in its final state.
`default_nettype none

module adsr_envelope_generator_unit
   import adsr_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  logic [VEL_W-1:0]                               req_velocity,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output logic [LEVEL_W-1:0]                             rsp_level,
   output logic [STAGE_W-1:0]                             rsp_stage_now,
   input  logic                                           csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]                         csr_index,
   input  logic [((LEN_BITS > LEVEL_W) ? LEN_BITS : LEVEL_W)-1:0] csr_wdata
);

   localparam int NUM_W = LEN_BITS + LEVEL_W;

   logic [LEN_BITS-1:0] attack_len_ff, decay_len_ff, release_len_ff;
   logic [LEVEL_W-1:0]  sus_ff;

   seq_state_type       seq_ff, seq_in;
   stage_type           stage_ff, stage_in;
   logic [LEN_BITS-1:0] idx_ff, idx_in;
   mode_type            mode_ff, mode_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [LEN_BITS-1:0] iu_ff, iu_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    dsr_ff, dsr_in;
   logic [QUOT_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   stage_type           rsp_stage_ff, rsp_stage_in;

   logic [LEVEL_W-1:0]  sus_eff;
   logic [LEVEL_W-1:0]  coef;
   logic                accept;
   logic                note_off;
   logic                vel_on;
   stage_type           stage_eff;
   stage_type           stage_next;
   logic [LEN_BITS-1:0] idx_eff;
   logic [LEN_BITS-1:0] len_sel;
   logic [LEN_BITS:0]   idx_sum;
   logic                timed;
   logic                out_free;

   assign sus_eff = (sus_ff > ONE_Q15) ? ONE_Q15 : sus_ff;
   assign req_ready = (seq_ff == SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= LEN_BITS'(ATTACK_RESET);
         decay_len_ff   <= LEN_BITS'(DECAY_RESET);
         sus_ff         <= SUSTAIN_RESET;
         release_len_ff <= LEN_BITS'(RELEASE_RESET);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ATTACK_LENGTH:  attack_len_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_DECAY_LENGTH:   decay_len_ff   <= csr_wdata[LEN_BITS-1:0];
            CSR_SUSTAIN_LEVEL:  sus_ff         <= csr_wdata[LEVEL_W-1:0];
            CSR_RELEASE_LENGTH: release_len_ff <= csr_wdata[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         stage_ff     <= STAGE_SILENT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         stage_ff     <= stage_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      len_ff       <= len_in;
      iu_ff        <= iu_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_level_ff <= rsp_level_in;
      rsp_stage_ff <= rsp_stage_in;
   end

   always_comb begin
      accept     = req_valid && req_ready;
      vel_on     = (req_velocity != '0);
      note_off   = !vel_on && (stage_ff inside {STAGE_ATTACK, STAGE_DECAY, STAGE_SUSTAIN});
      stage_eff  = note_off ? STAGE_RELEASE : stage_ff;
      idx_eff    = note_off ? '0 : idx_ff;
      timed      = 1'b0;
      len_sel    = attack_len_ff;
      stage_next = STAGE_DECAY;
      mode_in    = mode_ff;
      stage_in   = stage_ff;
      idx_in     = idx_ff;

      case (stage_eff)
         STAGE_ATTACK: begin
            timed      = 1'b1;
            len_sel    = attack_len_ff;
            stage_next = STAGE_DECAY;
         end
         STAGE_DECAY: begin
            timed      = 1'b1;
            len_sel    = decay_len_ff;
            stage_next = STAGE_SUSTAIN;
         end
         STAGE_SUSTAIN: begin
            mode_in  = MODE_SUSTAIN;
            stage_in = STAGE_SUSTAIN;
            idx_in   = idx_eff;
         end
         STAGE_RELEASE: begin
            if (vel_on) begin
               mode_in  = MODE_ZERO;
               stage_in = STAGE_ATTACK;
               idx_in   = '0;
            end else begin
               timed      = 1'b1;
               len_sel    = release_len_ff;
               stage_next = STAGE_SILENT;
            end
         end
         default: begin
            mode_in  = MODE_ZERO;
            stage_in = vel_on ? STAGE_ATTACK : STAGE_SILENT;
            idx_in   = vel_on ? '0 : idx_eff;
         end
      endcase

      // zero length counts as one
      if (len_sel == '0) begin
         len_sel = LEN_BITS'(1);
      end
      iu_in   = (idx_eff > len_sel) ? len_sel : idx_eff;
      len_in  = len_sel;
      idx_sum = {1'b0, idx_eff} + (LEN_BITS + 1)'(1);

      if (timed) begin
         case (stage_eff)
            STAGE_ATTACK: mode_in = MODE_ATTACK;
            STAGE_DECAY:  mode_in = MODE_DECAY;
            default:      mode_in = MODE_RELEASE;
         endcase
         if (idx_sum[LEN_BITS] || (idx_sum[LEN_BITS-1:0] >= len_sel)) begin
            idx_in   = '0;
            stage_in = stage_next;
         end else begin
            idx_in   = idx_sum[LEN_BITS-1:0];
            stage_in = stage_eff;
         end
      end

      if (!accept) begin
         mode_in  = mode_ff;
         stage_in = stage_ff;
         idx_in   = idx_ff;
         iu_in    = iu_ff;
         len_in   = len_ff;
      end

      case (mode_ff)
         MODE_ATTACK:  coef = ONE_Q15;
         MODE_DECAY:   coef = ONE_Q15 - sus_eff;
         MODE_RELEASE: coef = sus_eff;
         default:      coef = '0;
      endcase

      out_free     = !rsp_valid_ff || rsp_ready;
      seq_in       = seq_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_stage_in = rsp_stage_ff;

      case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               seq_in = timed ? SEQ_MUL : SEQ_FIN;
            end
         end
         SEQ_MUL: begin
            rem_in = {{LEN_BITS{1'b0}}, coef} * {{LEVEL_W{1'b0}}, iu_ff};
            dsr_in = NUM_W'({len_ff, {(QUOT_W-1){1'b0}}});
            quo_in = '0;
            cnt_in = '0;
            seq_in = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(QUOT_W - 1)) begin
               seq_in = SEQ_FIN;
            end
         end
         SEQ_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stage_in = stage_ff;
               case (mode_ff)
                  MODE_ATTACK:  rsp_level_in = quo_ff;
                  MODE_DECAY:   rsp_level_in = ONE_Q15 - quo_ff;
                  MODE_RELEASE: rsp_level_in = sus_eff - quo_ff;
                  MODE_SUSTAIN: rsp_level_in = sus_eff;
                  default:      rsp_level_in = '0;
               endcase
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_stage_now = rsp_stage_ff;

   // sustain and silent are only ever entered with a cleared index
   a_idx_clear : assert property (@(posedge clock) disable iff (reset)
      (stage_ff == STAGE_SUSTAIN || stage_ff == STAGE_SILENT) |-> (idx_ff == '0))
      else $error("index nonzero in sustain or silent");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   a_quot_range : assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FIN && (mode_ff == MODE_ATTACK || mode_ff == MODE_DECAY ||
       mode_ff == MODE_RELEASE)) |-> (quo_ff <= ONE_Q15))
      else $error("quotient above one");

   a_fin_loads : assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FIN && (!rsp_valid_ff || rsp_ready)) |=> (rsp_valid_ff && req_ready))
      else $error("finished word not loaded");

endmodule

`default_nettype wire

// ===== verif/adsr_envelope_generator_unit_tb.sv =====
// Testbench for adsr_envelope_generator_unit: directed and random velocity words
// checked against an in-bench envelope predictor, with random stalls on both sides.
// Depends on adsr_pkg and adsr_envelope_generator_unit.
`timescale 1ns / 100ps

module adsr_envelope_generator_unit_tb
   import adsr_pkg::*;
();

   localparam int LEN_BITS = LEN_BITS_DEFAULT;
   localparam int CSR_W    = (LEN_BITS > LEVEL_W) ? LEN_BITS : LEVEL_W;
   localparam int LEN_MAX  = (1 << LEN_BITS) - 1;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      stage_type          stage;
   } envelope_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [VEL_W-1:0]         req_velocity = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]       rsp_level;
   logic [STAGE_W-1:0]       rsp_stage_now;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;

   // predictor state, mirrors the block's registers
   logic [LEN_BITS-1:0]      attack_len_m  = LEN_BITS'(ATTACK_RESET);
   logic [LEN_BITS-1:0]      decay_len_m   = LEN_BITS'(DECAY_RESET);
   logic [LEN_BITS-1:0]      release_len_m = LEN_BITS'(RELEASE_RESET);
   logic [LEVEL_W-1:0]       sustain_m     = SUSTAIN_RESET;
   stage_type                env_stage     = STAGE_SILENT;
   logic [LEN_BITS-1:0]      env_index     = '0;

   envelope_word_type        pending_envelope [$];
   envelope_word_type        head_word;
   int                       mismatches = 0;
   int                       words_checked = 0;
   bit                       idling_on = 1'b0;
   int                       rsp_hold_cycles = 0;

   adsr_envelope_generator_unit #(
      .LEN_BITS(LEN_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_velocity(req_velocity),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_level(rsp_level),
      .rsp_stage_now(rsp_stage_now),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("FAIL adsr_envelope_generator_unit");
      $finish;
   end

   function automatic logic [63:0] ramp_length(input logic [LEN_BITS-1:0] len);
      return (len == '0) ? 64'd1 : 64'(len);
   endfunction

   function automatic envelope_word_type envelope_step(input logic [VEL_W-1:0] vel);
      logic [63:0]       sus, len, idx, lvl;
      stage_type         next_stage;
      bit                ramping;
      envelope_word_type w;
      sus = (sustain_m > ONE_Q15) ? 64'(ONE_Q15) : 64'(sustain_m);
      lvl = '0;
      len = 64'd1;
      ramping = 1'b0;
      next_stage = STAGE_SILENT;
      if (vel == '0 && (env_stage == STAGE_ATTACK || env_stage == STAGE_DECAY ||
                        env_stage == STAGE_SUSTAIN)) begin
         env_stage = STAGE_RELEASE;
         env_index = '0;
      end
      case (env_stage)
         STAGE_ATTACK: begin
            len = ramp_length(attack_len_m);
            idx = (64'(env_index) > len) ? len : 64'(env_index);
            lvl = (idx * 64'(ONE_Q15)) / len;
            ramping = 1'b1;
            next_stage = STAGE_DECAY;
         end
         STAGE_DECAY: begin
            len = ramp_length(decay_len_m);
            idx = (64'(env_index) > len) ? len : 64'(env_index);
            lvl = 64'(ONE_Q15) - ((64'(ONE_Q15) - sus) * idx) / len;
            ramping = 1'b1;
            next_stage = STAGE_SUSTAIN;
         end
         STAGE_SUSTAIN: begin
            lvl = sus;
         end
         STAGE_RELEASE: begin
            if (vel != '0) begin
               env_stage = STAGE_ATTACK;
               env_index = '0;
            end else begin
               len = ramp_length(release_len_m);
               idx = (64'(env_index) > len) ? len : 64'(env_index);
               lvl = sus - (sus * idx) / len;
               ramping = 1'b1;
               next_stage = STAGE_SILENT;
            end
         end
         default: begin
            env_stage = (vel != '0) ? STAGE_ATTACK : STAGE_SILENT;
            env_index = '0;
         end
      endcase
      if (ramping) begin
         env_index = env_index + LEN_BITS'(1);
         if (64'(env_index) >= len || env_index == '0) begin
            env_index = '0;
            env_stage = next_stage;
         end
      end
      w.level = lvl[LEVEL_W-1:0];
      w.stage = env_stage;
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pending_envelope.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected word level=%0d stage=%0d",
                        rsp_level, rsp_stage_now);
         end else begin
            head_word = pending_envelope.pop_front();
            if (rsp_level !== head_word.level || rsp_stage_now !== head_word.stage) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: word %0d level exp %0d got %0d, stage exp %0d got %0d",
                           words_checked, head_word.level, rsp_level,
                           head_word.stage, rsp_stage_now);
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold on request
   initial begin : rsp_ready_driver
      int gap;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic [VEL_W-1:0] vel);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_velocity <= vel;
      do @(posedge clock); while (!req_ready);
      pending_envelope.push_back(envelope_step(vel));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_envelope.size() != 0);
   endtask

   task automatic reconfigure(input int attack, input int decay, input int sustain,
                              input int rel_len);
      logic [CSR_W-1:0] values [4];
      csr_index_type    order [4];
      order = '{CSR_ATTACK_LENGTH, CSR_DECAY_LENGTH, CSR_SUSTAIN_LEVEL, CSR_RELEASE_LENGTH};
      values = '{CSR_W'(attack), CSR_W'(decay), CSR_W'(sustain), CSR_W'(rel_len)};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      attack_len_m  = values[0][LEN_BITS-1:0];
      decay_len_m   = values[1][LEN_BITS-1:0];
      sustain_m     = values[2][LEVEL_W-1:0];
      release_len_m = values[3][LEN_BITS-1:0];
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(1000, LEN_MAX);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   task automatic random_settings();
      int sustain;
      case ($urandom_range(0, 5))
         0: sustain = 0;
         1: sustain = 32768;
         2: sustain = $urandom_range(32769, 65535);
         default: sustain = $urandom_range(0, 32768);
      endcase
      reconfigure(pick_length(), pick_length(), sustain, pick_length());
   endtask

   // note-on runs, note-off runs and noise words
   task automatic play_notes(input int count);
      int               sent;
      int               run;
      logic [VEL_W-1:0] vel;
      sent = 0;
      while (sent < count) begin
         run = $urandom_range(1, 48);
         if (run > count - sent)
            run = count - sent;
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat (run / 4 + 1) begin
                  send_sample(VEL_W'($urandom_range(0, 127)));
                  sent++;
               end
            end
            2, 3, 4, 5, 6: begin
               vel = VEL_W'($urandom_range(1, 127));
               repeat (run) begin
                  if ($urandom_range(0, 7) == 0)
                     vel = VEL_W'($urandom_range(1, 127));
                  send_sample(vel);
                  sent++;
               end
            end
            default: begin
               repeat (run / 2 + 1) begin
                  send_sample('0);
                  sent++;
               end
            end
         endcase
      end
   endtask

   task automatic test_reset_settings();
      send_sample(7'd0);
      send_sample(7'd127);
      send_sample(7'd64);
      send_sample(7'd0);
      send_sample(7'd0);
      send_sample(7'd1);
      send_sample(7'd0);
   endtask

   task automatic test_length_extremes();
      // zero lengths act as one; sustain above one saturates
      reconfigure(0, 0, 65535, 0);
      repeat (3) send_sample(7'd1);
      repeat (2) send_sample(7'd0);
      reconfigure(LEN_MAX, 1, 0, LEN_MAX);
      repeat (2) send_sample(7'd127);
      repeat (2) send_sample(7'd0);
   endtask

   task automatic test_length_lowered_midstage();
      reconfigure(40, 3, 32768, 40);
      repeat (6) send_sample(7'd85);
      reconfigure(2, 3, 32768, 40);
      send_sample(7'd85);
      repeat (3) send_sample(7'd0);
      reconfigure(2, 3, 32768, 2);
      send_sample(7'd0);
   endtask

   task automatic test_output_backpressure();
      reconfigure(3, 2, 12000, 3);
      rsp_hold_cycles = 80;
      repeat (8) send_sample(7'd100);
      repeat (4) send_sample(7'd0);
      wait_drained();
   endtask

   task automatic test_random_envelopes();
      idling_on = 1'b1;
      repeat (8) begin
         random_settings();
         play_notes(40);
      end
   endtask

   task automatic test_unthrottled_tail();
      idling_on = 1'b0;
      random_settings();
      play_notes(60);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_length_extremes();
      test_length_lowered_midstage();
      test_output_backpressure();
      test_random_envelopes();
      test_unthrottled_tail();
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_envelope.size() == 0) begin
         $display("PASS adsr_envelope_generator_unit");
      end else begin
         $display("FAIL adsr_envelope_generator_unit");
      end
      $finish;
   end

endmodule
